### design/lswc_pkg.sv
// ---------------------------------------------------------------------------
// Line segment window clip package
// Shared types and constants for the pipelined parametric segment clipper.
// ---------------------------------------------------------------------------
package lswc_pkg;

   localparam int CoordWidth = 12;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int NumEdges   = 4;
   localparam int CsrIndexWidth = 2;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [DiffWidth-1:0]  diff_type;

   localparam logic [CsrIndexWidth-1:0] CsrWindowLeft   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrWindowBottom = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrWindowRight  = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrWindowTop    = 2'd3;

   localparam coord_type WindowLeftReset   = -12'sd70;
   localparam coord_type WindowBottomReset = -12'sd50;
   localparam coord_type WindowRightReset  = 12'sd70;
   localparam coord_type WindowTopReset    = 12'sd50;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic      visible;
      coord_type clipped_start_x;
      coord_type clipped_start_y;
      coord_type clipped_end_x;
      coord_type clipped_end_y;
   } rsp_type;

   // Per-edge classification of the direction and distance terms.
   typedef struct packed {
      logic p_neg;
      logic p_zero;
      logic q_neg;
      logic sat;
   } edge_flags_type;

   typedef struct packed {
      coord_type x1;
      coord_type y1;
      diff_type  dx;
      diff_type  dy;
      edge_flags_type [NumEdges-1:0] flags;
   } side_type;

endpackage

### design/lswc_div.sv
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per stage of |q| * 2^F / |p| for |q| < 2|p|.
// ---------------------------------------------------------------------------
module lswc_div import lswc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic [FRAC_BITS:0]   load,
   input  logic [DiffWidth-1:0] divisor,
   input  logic [DiffWidth-1:0] dividend,
   output logic [FRAC_BITS:0]   quotient
);

   localparam int Steps    = FRAC_BITS + 1;
   localparam int RemWidth = DiffWidth + 1;

   logic [RemWidth-1:0]  rem_ff [Steps];
   logic [DiffWidth-1:0] dvs_ff [Steps];
   logic [FRAC_BITS:0]   quo_ff [Steps];

   for (genvar j = 0; j < Steps; j++) begin : g_step
      logic [RemWidth-1:0]  rem_prev;
      logic [DiffWidth-1:0] dvs_prev;
      logic [FRAC_BITS:0]   quo_prev;
      logic                 take;
      logic [RemWidth-1:0]  rem_in;
      logic [FRAC_BITS:0]   quo_in;

      if (j == 0) begin : g_first
         assign rem_prev = {1'b0, dividend};
         assign dvs_prev = divisor;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign dvs_prev = dvs_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      assign take   = rem_prev >= {1'b0, dvs_prev};
      assign rem_in = (take ? (rem_prev - {1'b0, dvs_prev}) : rem_prev) << 1;
      assign quo_in = {quo_prev[FRAC_BITS-1:0], take};

      always_ff @(posedge clock) begin
         if (load[j]) begin
            rem_ff[j] <= rem_in;
            dvs_ff[j] <= dvs_prev;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign quotient = quo_ff[Steps-1];

endmodule

### design/lswc_clip.sv
// ---------------------------------------------------------------------------
// Edge test stage
// Runs the left, right, bottom and top tests in order and registers u1, u2.
// ---------------------------------------------------------------------------
module lswc_clip import lswc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [FRAC_BITS:0]            quotient [NumEdges],
   input  edge_flags_type [NumEdges-1:0] flags,
   output logic [FRAC_BITS:0]            u_entry,
   output logic [FRAC_BITS:0]            u_exit,
   output logic                          pass
);

   localparam logic [FRAC_BITS+1:0] SatMag = (FRAC_BITS+2)'((1 << FRAC_BITS) + 1);
   localparam logic signed [FRAC_BITS+2:0] One = (FRAC_BITS+3)'(1 << FRAC_BITS);

   logic [FRAC_BITS:0] lo_ff, lo_in, hi_ff, hi_in;
   logic               pass_ff, pass_in;

   always_comb begin
      logic signed [FRAC_BITS+2:0] lo, hi, r;
      logic [FRAC_BITS+1:0]        mag;
      lo = '0;
      hi = One;
      pass_in = 1'b1;
      for (int e = 0; e < NumEdges; e++) begin
         // A quotient of 2.0 or more behaves exactly like one just above 1.0.
         mag = flags[e].sat ? SatMag : {1'b0, quotient[e]};
         r = (flags[e].p_neg ^ flags[e].q_neg) ? -signed'({1'b0, mag})
                                                : signed'({1'b0, mag});
         if (pass_in) begin
            if (flags[e].p_zero) begin
               if (flags[e].q_neg) pass_in = 1'b0;
            end else if (flags[e].p_neg) begin
               if (r > hi) pass_in = 1'b0;
               else if (r > lo) lo = r;
            end else begin
               if (r < lo) pass_in = 1'b0;
               else if (r < hi) hi = r;
            end
         end
      end
      lo_in = lo[FRAC_BITS:0];
      hi_in = hi[FRAC_BITS:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         pass_ff <= pass_in;
      end
   end

   assign u_entry = lo_ff;
   assign u_exit  = hi_ff;
   assign pass    = pass_ff;

endmodule

### design/lswc_point.sv
// ---------------------------------------------------------------------------
// Endpoint interpolation
// Multiplies u1 and u2 by one axis delta, then adds the base and truncates.
// ---------------------------------------------------------------------------
module lswc_point import lswc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               load_mul,
   input  logic               load_out,
   input  coord_type          base,
   input  diff_type           delta,
   input  logic [FRAC_BITS:0] u_entry,
   input  logic [FRAC_BITS:0] u_exit,
   input  logic               keep,
   output coord_type          point_start,
   output coord_type          point_end
);

   localparam int ProdWidth = FRAC_BITS + 1 + DiffWidth + 1;
   localparam int SumWidth  = FRAC_BITS + CoordWidth + 3;
   localparam logic signed [SumWidth-1:0] Bias = SumWidth'((1 << FRAC_BITS) - 1);

   logic signed [ProdWidth-1:0] prod_lo_ff, prod_hi_ff;
   coord_type                   base_ff;
   coord_type                   start_ff, start_in, end_ff, end_in;

   function automatic coord_type to_coord(input coord_type b,
                                          input logic signed [ProdWidth-1:0] p);
      logic signed [SumWidth-1:0] sum, adj, shifted;
      sum = (SumWidth'(b) <<< FRAC_BITS) + SumWidth'(p);
      // Truncate toward zero.
      adj = sum[SumWidth-1] ? sum + Bias : sum;
      shifted = adj >>> FRAC_BITS;
      return shifted[CoordWidth-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (load_mul) begin
         prod_lo_ff <= signed'({1'b0, u_entry}) * delta;
         prod_hi_ff <= signed'({1'b0, u_exit}) * delta;
         base_ff    <= base;
      end
   end

   assign start_in = keep ? to_coord(base_ff, prod_lo_ff) : '0;
   assign end_in   = keep ? to_coord(base_ff, prod_hi_ff) : '0;

   always_ff @(posedge clock) begin
      if (load_out) begin
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   assign point_start = start_ff;
   assign point_end   = end_ff;

endmodule

### design/line_segment_window_clip.sv
// ---------------------------------------------------------------------------
// Line segment window clip
// Parametric clipping of 2-D segments against a programmable window.
// ---------------------------------------------------------------------------
// Usage: a request carries one segment (start and end point). The result
// channel returns one response per request, in order: a visible flag and the
// clipped endpoints, all zero when the segment misses the window.
// The window edges are written through the csr_ port; the user must write
// them only while the block is idle, which the block does not enforce. Reset
// loads left -70, bottom -50, right 70, top 50. One request is taken every
// cycle while the response side is not stalled. The pipeline is a front
// stage, then the quotient divider, which resolves one quotient bit per stage
// in four parallel lanes, then the edge test, multiply and output stages.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled response holds only the stages behind it that are full, and empty
// stages keep filling. Reset empties the pipeline.
// ---------------------------------------------------------------------------
module line_segment_window_clip import lswc_pkg::*; #(
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  coord_type                csr_data
);

   localparam int NumDiv    = PARAM_FRAC_BITS + 1;
   localparam int StClip    = NumDiv + 1;
   localparam int StMul     = NumDiv + 2;
   localparam int StOut     = NumDiv + 3;
   localparam int NumStages = NumDiv + 4;

   coord_type left_ff, bottom_ff, right_ff, top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= WindowLeftReset;
         bottom_ff <= WindowBottomReset;
         right_ff  <= WindowRightReset;
         top_ff    <= WindowTopReset;
      end else if (csr_write) begin
         case (csr_index)
            CsrWindowLeft:   left_ff   <= csr_data;
            CsrWindowBottom: bottom_ff <= csr_data;
            CsrWindowRight:  right_ff  <= csr_data;
            CsrWindowTop:    top_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage handshake.
   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] stage_load;

   always_comb begin
      stage_load[NumStages-1] = !valid_ff[NumStages-1] || !rsp_stall;
      for (int k = NumStages - 2; k >= 0; k--) begin
         stage_load[k] = !valid_ff[k] || stage_load[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_load[0]) valid_ff[0] <= req_valid;
         for (int k = 1; k < NumStages; k++) begin
            if (stage_load[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign req_stall = !stage_load[0];
   assign rsp_valid = valid_ff[NumStages-1];

   // Front stage: direction and distance terms of the left, right, bottom and top edges.
   function automatic logic [DiffWidth-1:0] magnitude(input diff_type v);
      return v[DiffWidth-1] ? DiffWidth'(-v) : DiffWidth'(v);
   endfunction

   diff_type             dx, dy;
   diff_type             p_val [NumEdges];
   diff_type             q_val [NumEdges];
   side_type             side_in;
   side_type             side_ff [NumDiv+1];
   logic [DiffWidth-1:0] pmag_ff [NumEdges];
   logic [DiffWidth-1:0] qmag_ff [NumEdges];
   logic [DiffWidth-1:0] pmag_in [NumEdges];
   logic [DiffWidth-1:0] qmag_in [NumEdges];

   assign dx = diff_type'(req_data.end_x) - diff_type'(req_data.start_x);
   assign dy = diff_type'(req_data.end_y) - diff_type'(req_data.start_y);

   assign p_val[0] = -dx;
   assign q_val[0] = diff_type'(req_data.start_x) - diff_type'(left_ff);
   assign p_val[1] = dx;
   assign q_val[1] = diff_type'(right_ff) - diff_type'(req_data.start_x);
   assign p_val[2] = -dy;
   assign q_val[2] = diff_type'(req_data.start_y) - diff_type'(bottom_ff);
   assign p_val[3] = dy;
   assign q_val[3] = diff_type'(top_ff) - diff_type'(req_data.start_y);

   always_comb begin
      side_in.x1 = req_data.start_x;
      side_in.y1 = req_data.start_y;
      side_in.dx = dx;
      side_in.dy = dy;
      for (int e = 0; e < NumEdges; e++) begin
         pmag_in[e] = magnitude(p_val[e]);
         qmag_in[e] = magnitude(q_val[e]);
         side_in.flags[e].p_neg  = p_val[e][DiffWidth-1];
         side_in.flags[e].p_zero = (p_val[e] == '0);
         side_in.flags[e].q_neg  = q_val[e][DiffWidth-1];
         // The quotient reaches 2.0 exactly when |q| >= 2|p|.
         side_in.flags[e].sat    = {1'b0, qmag_in[e]} >= {pmag_in[e], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         side_ff[0] <= side_in;
         pmag_ff    <= pmag_in;
         qmag_ff    <= qmag_in;
      end
      for (int j = 1; j <= NumDiv; j++) begin
         if (stage_load[j]) side_ff[j] <= side_ff[j-1];
      end
   end

   // Divider lanes, one per edge.
   logic [PARAM_FRAC_BITS:0] quotient [NumEdges];

   for (genvar e = 0; e < NumEdges; e++) begin : g_lane
      lswc_div #(.FRAC_BITS(PARAM_FRAC_BITS)) u_div (
         .clock    (clock),
         .load     (stage_load[NumDiv:1]),
         .divisor  (pmag_ff[e]),
         .dividend (qmag_ff[e]),
         .quotient (quotient[e])
      );
   end

   // Edge tests.
   logic [PARAM_FRAC_BITS:0] u_entry, u_exit;
   logic                     pass;
   side_type                 clip_side_ff;
   logic                     keep_ff;

   lswc_clip #(.FRAC_BITS(PARAM_FRAC_BITS)) u_clip (
      .clock    (clock),
      .load     (stage_load[StClip]),
      .quotient (quotient),
      .flags    (side_ff[NumDiv].flags),
      .u_entry  (u_entry),
      .u_exit   (u_exit),
      .pass     (pass)
   );

   always_ff @(posedge clock) begin
      if (stage_load[StClip]) clip_side_ff <= side_ff[NumDiv];
      if (stage_load[StMul])  keep_ff      <= pass;
   end

   // Endpoint interpolation and output register.
   coord_type start_x, start_y, end_x, end_y;
   logic      visible_ff;

   lswc_point #(.FRAC_BITS(PARAM_FRAC_BITS)) u_point_x (
      .clock       (clock),
      .load_mul    (stage_load[StMul]),
      .load_out    (stage_load[StOut]),
      .base        (clip_side_ff.x1),
      .delta       (clip_side_ff.dx),
      .u_entry     (u_entry),
      .u_exit      (u_exit),
      .keep        (keep_ff),
      .point_start (start_x),
      .point_end   (end_x)
   );

   lswc_point #(.FRAC_BITS(PARAM_FRAC_BITS)) u_point_y (
      .clock       (clock),
      .load_mul    (stage_load[StMul]),
      .load_out    (stage_load[StOut]),
      .base        (clip_side_ff.y1),
      .delta       (clip_side_ff.dy),
      .u_entry     (u_entry),
      .u_exit      (u_exit),
      .keep        (keep_ff),
      .point_start (start_y),
      .point_end   (end_y)
   );

   always_ff @(posedge clock) begin
      if (stage_load[StOut]) visible_ff <= keep_ff;
   end

   assign rsp_data.visible         = visible_ff;
   assign rsp_data.clipped_start_x = start_x;
   assign rsp_data.clipped_start_y = start_y;
   assign rsp_data.clipped_end_x   = end_x;
   assign rsp_data.clipped_end_y   = end_y;

endmodule

### design/lswc_check.sv
// ---------------------------------------------------------------------------
// Line segment window clip checker
// Port-level properties of the clipper, attached to the top level by bind.
// ---------------------------------------------------------------------------
module lswc_check import lswc_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input rsp_type                  rsp_data
);

   // A stalled response stays and holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A rejected segment reports zero coordinates.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.visible |->
         rsp_data.clipped_start_x == '0 && rsp_data.clipped_start_y == '0 &&
         rsp_data.clipped_end_x == '0 && rsp_data.clipped_end_y == '0)
      else $error("rejected segment with nonzero coordinates");

   // With the response side free, the pipeline always takes a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while responses drain");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind line_segment_window_clip lswc_check u_lswc_check (.*);

### verif/tb_line_segment_window_clip.sv
// ---------------------------------------------------------------------------
// Line segment window clip testbench
// Drives segments through the clipper under random valid and stall patterns,
// predicts each response not given as known with a behavioral Liang-Barsky
// clipper in fixed point, and compares every response field by field in order.
// ---------------------------------------------------------------------------
module tb_line_segment_window_clip;
   timeunit 1ns;
   timeprecision 1ps;
   import lswc_pkg::*;

   localparam int FracBits = 16;
   localparam int Latency  = FracBits + 5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   coord_type csr_data = '0;

   line_segment_window_clip #(.PARAM_FRAC_BITS(FracBits)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Window copy held by the predictor.
   longint win_left, win_bottom, win_right, win_top;
   rsp_type clipped_q[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic bit edge_pass(longint p, longint q, inout longint lo,
                                    inout longint hi);
      longint r;
      if (p != 0) begin
         r = (q * (longint'(1) << FracBits)) / p;
         if (p < 0) begin
            if (r > hi) return 1'b0;
            if (r > lo) lo = r;
         end else begin
            if (r < lo) return 1'b0;
            if (r < hi) hi = r;
         end
      end else if (q < 0) begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic coord_type coord_at(longint base, longint delta, longint u);
      longint one;
      one = longint'(1) << FracBits;
      return coord_type'((base * one + u * delta) / one);
   endfunction

   function automatic rsp_type clip_segment(req_type s);
      longint x1, y1, dx, dy, lo, hi;
      bit ok;
      rsp_type r;
      x1 = s.start_x;
      y1 = s.start_y;
      dx = longint'(s.end_x) - x1;
      dy = longint'(s.end_y) - y1;
      lo = 0;
      hi = longint'(1) << FracBits;
      r = '0;
      ok = edge_pass(-dx, x1 - win_left, lo, hi);
      if (ok) ok = edge_pass(dx, win_right - x1, lo, hi);
      if (ok) ok = edge_pass(-dy, y1 - win_bottom, lo, hi);
      if (ok) ok = edge_pass(dy, win_top - y1, lo, hi);
      if (ok) begin
         r.visible = 1'b1;
         r.clipped_start_x = coord_at(x1, dx, lo);
         r.clipped_start_y = coord_at(y1, dy, lo);
         r.clipped_end_x = coord_at(x1, dx, hi);
         r.clipped_end_y = coord_at(y1, dy, hi);
      end
      return r;
   endfunction

   task automatic write_window(logic [CsrIndexWidth-1:0] idx, coord_type v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CsrWindowLeft: win_left = v;
         CsrWindowBottom: win_bottom = v;
         CsrWindowRight: win_right = v;
         default: win_top = v;
      endcase
   endtask

   task automatic set_window(coord_type l, coord_type b, coord_type r, coord_type t);
      write_window(CsrWindowLeft, l);
      write_window(CsrWindowBottom, b);
      write_window(CsrWindowRight, r);
      write_window(CsrWindowTop, t);
   endtask

   // Sends one segment; a known response, when given, overrides the prediction.
   task automatic send_segment(req_type s, bit known, rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      clipped_q.push_back(known ? want : clip_segment(s));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain;
      while (clipped_q.size() != 0) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b0;
      repeat (Latency + 4) @(posedge clock);
   endtask

   function automatic coord_type rand_coord();
      return coord_type'($urandom_range(4095));
   endfunction

   // Mostly segments near the window so that clipping happens.
   function automatic coord_type near_coord(longint lo_edge, longint hi_edge);
      longint v;
      v = lo_edge - 40 + longint'($urandom_range(int'(hi_edge - lo_edge + 80)));
      if (v > 2047) v = 2047;
      if (v < -2048) v = -2048;
      return coord_type'(v);
   endfunction

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (clipped_q.size() == 0) begin
            report_mismatch("unexpected response", 0, 0);
         end else begin
            rsp_type w;
            w = clipped_q.pop_front();
            if (rsp_data.visible !== w.visible)
               report_mismatch("visible", rsp_data.visible, w.visible);
            if (rsp_data.clipped_start_x !== w.clipped_start_x)
               report_mismatch("clipped_start_x", rsp_data.clipped_start_x,
                               w.clipped_start_x);
            if (rsp_data.clipped_start_y !== w.clipped_start_y)
               report_mismatch("clipped_start_y", rsp_data.clipped_start_y,
                               w.clipped_start_y);
            if (rsp_data.clipped_end_x !== w.clipped_end_x)
               report_mismatch("clipped_end_x", rsp_data.clipped_end_x, w.clipped_end_x);
            if (rsp_data.clipped_end_y !== w.clipped_end_y)
               report_mismatch("clipped_end_y", rsp_data.clipped_end_y, w.clipped_end_y);
         end
      end
   end

   typedef struct {
      req_type seg;
      bit known;
      rsp_type want;
   } vector_type;

   vector_type directed[] = '{
      '{'{12'sd0, 12'sd0, 12'sd0, 12'sd0}, 1'b1, '{1'b1, 0, 0, 0, 0}},
      '{'{12'sd100, 12'sd100, 12'sd100, 12'sd100}, 1'b1, '0},
      '{'{-12'sd70, -12'sd50, -12'sd70, -12'sd50}, 1'b1,
        '{1'b1, -12'sd70, -12'sd50, -12'sd70, -12'sd50}},
      '{'{-12'sd2048, 12'sd0, 12'sd2047, 12'sd0}, 1'b1,
        '{1'b1, -12'sd70, 12'sd0, 12'sd69, 12'sd0}},
      '{'{12'sd0, -12'sd2048, 12'sd0, 12'sd2047}, 1'b1,
        '{1'b1, 12'sd0, -12'sd50, 12'sd0, 12'sd49}},
      '{'{-12'sd2048, -12'sd2048, -12'sd2048, 12'sd2047}, 1'b1, '0},
      '{'{12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048}, 1'b0, '0},
      '{'{-12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048}, 1'b0, '0},
      '{'{-12'sd100, 12'sd50, 12'sd100, 12'sd50}, 1'b1,
        '{1'b1, -12'sd70, 12'sd50, 12'sd69, 12'sd50}},
      '{'{-12'sd80, 12'sd60, -12'sd60, 12'sd40}, 1'b0, '0},
      '{'{12'sd10, 12'sd10, 12'sd20, 12'sd30}, 1'b1,
        '{1'b1, 12'sd10, 12'sd10, 12'sd20, 12'sd30}},
      '{'{12'sd0, 12'sd0, 12'sd200, 12'sd90}, 1'b0, '0},
      '{'{12'sd70, 12'sd0, 12'sd90, 12'sd0}, 1'b0, '0},
      '{'{12'sd0, 12'sd0, -12'sd2048, -12'sd1}, 1'b0, '0}
   };

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      coord_type l, b;
      req_type s;
      win_left = WindowLeftReset;
      win_bottom = WindowBottomReset;
      win_right = WindowRightReset;
      win_top = WindowTopReset;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_segment(directed[i].seg, directed[i].known,
                                         directed[i].want);
      drain();

      // Full-range window, then an inverted one, then a single-point window.
      set_window(-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
      send_segment('{-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047}, 1'b1,
                   '{1'b1, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047});
      send_segment('{12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047}, 1'b0, '0);
      drain();
      set_window(12'sd50, 12'sd50, -12'sd50, -12'sd50);
      send_segment('{-12'sd100, 12'sd0, 12'sd100, 12'sd0}, 1'b0, '0);
      send_segment('{12'sd0, 12'sd0, 12'sd0, 12'sd0}, 1'b1, '0);
      drain();
      set_window(12'sd5, 12'sd5, 12'sd5, 12'sd5);
      send_segment('{12'sd0, 12'sd0, 12'sd10, 12'sd10}, 1'b0, '0);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 78 : 0;
         recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 21 : 0;
         for (int w = 0; w < 5; w++) begin
            if (w == 0 && phase == 0) begin
               set_window(WindowLeftReset, WindowBottomReset, WindowRightReset,
                          WindowTopReset);
            end else begin
               l = coord_type'(int'($urandom_range(3000)) - 2048);
               b = coord_type'(int'($urandom_range(3000)) - 2048);
               set_window(l, b,
                          coord_type'(int'(l) + int'($urandom_range(2047 - int'(l)))),
                          coord_type'(int'(b) + int'($urandom_range(2047 - int'(b)))));
               if ($urandom_range(9) == 0) write_window(CsrWindowRight, rand_coord());
            end
            for (int n = 0; n < 110; n++) begin
               case ($urandom_range(9))
                  0, 1: s = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
                  2: begin
                     s.start_x = near_coord(win_left, win_right);
                     s.start_y = near_coord(win_bottom, win_top);
                     s.end_x = s.start_x;
                     s.end_y = s.start_y;
                  end
                  default: begin
                     s.start_x = near_coord(win_left, win_right);
                     s.start_y = near_coord(win_bottom, win_top);
                     s.end_x = near_coord(win_left, win_right);
                     s.end_y = near_coord(win_bottom, win_top);
                  end
               endcase
               send_segment(s, 1'b0, '0);
            end
            drain();
         end
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

### line_segment_window_clip.f
design/lswc_pkg.sv
design/lswc_div.sv
design/lswc_clip.sv
design/lswc_point.sv
design/line_segment_window_clip.sv
design/lswc_check.sv
verif/tb_line_segment_window_clip.sv
